// ===== sv/task_dependency_scoreboard_macros.svh =====
// ----------------------------------------------------------------------------
// Task dependency scoreboard assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TASK_DEPENDENCY_SCOREBOARD_MACROS_SVH
`define TASK_DEPENDENCY_SCOREBOARD_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define TDS_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("task_dependency_scoreboard: check failed");

// condition must hold in the cycle after the trigger
`define TDS_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("task_dependency_scoreboard: check failed");

`endif

// ===== sv/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// Task dependency scoreboard package
// Sizes, command, result and state codes, and the controller/datapath links.
// ----------------------------------------------------------------------------
package tds_pkg;

	localparam int MAX_STEPS   = 16;
	localparam int IDX_W       = $clog2(MAX_STEPS);
	localparam int CNT_W       = $clog2(MAX_STEPS + 1);
	localparam int WORKER_BITS = 8;
	localparam int TIME_W      = 40;
	localparam int CMD_W       = 4;
	localparam int RC_W        = 4;
	localparam int FLOW_W      = 2;
	localparam int ST_W        = 3;
	localparam int OP_W        = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_COMMIT  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DONE    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_FAILED  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_UNCLAIM = 4'd5;
	localparam logic [CMD_W-1:0] CMD_CLAIM   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_CANCEL  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_SWEEP   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_STATUS  = 4'd9;

	localparam logic [RC_W-1:0] RC_OK            = 4'd0;
	localparam logic [RC_W-1:0] RC_NO_STEP       = 4'd1;
	localparam logic [RC_W-1:0] RC_ALREADY_DONE  = 4'd2;
	localparam logic [RC_W-1:0] RC_CANCELLED     = 4'd3;
	localparam logic [RC_W-1:0] RC_DEPS_PENDING  = 4'd4;
	localparam logic [RC_W-1:0] RC_NOT_CLAIMED   = 4'd5;
	localparam logic [RC_W-1:0] RC_BAD_WORKER    = 4'd6;
	localparam logic [RC_W-1:0] RC_FULL          = 4'd7;
	localparam logic [RC_W-1:0] RC_NOT_COMMITTED = 4'd8;
	localparam logic [RC_W-1:0] RC_COMMITTED     = 4'd9;
	localparam logic [RC_W-1:0] RC_UNKNOWN_DEP   = 4'd10;
	localparam logic [RC_W-1:0] RC_CYCLIC        = 4'd11;
	localparam logic [RC_W-1:0] RC_EMPTY         = 4'd12;

	localparam logic [FLOW_W-1:0] FLOW_ACTIVE    = 2'd0;
	localparam logic [FLOW_W-1:0] FLOW_DONE      = 2'd1;
	localparam logic [FLOW_W-1:0] FLOW_CANCELLED = 2'd2;
	localparam logic [FLOW_W-1:0] FLOW_FAILED    = 2'd3;

	localparam logic [ST_W-1:0] ST_PENDING   = 3'd0;
	localparam logic [ST_W-1:0] ST_CLAIMED   = 3'd1;
	localparam logic [ST_W-1:0] ST_DONE      = 3'd2;
	localparam logic [ST_W-1:0] ST_FAILED    = 3'd3;
	localparam logic [ST_W-1:0] ST_OVERDUE   = 3'd4;
	localparam logic [ST_W-1:0] ST_CANCELLED = 3'd5;

	// how a captured transaction is carried out
	localparam logic [OP_W-1:0] OP_SIMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_SCAN   = 2'd1;
	localparam logic [OP_W-1:0] OP_KAHN   = 2'd2;
	localparam logic [OP_W-1:0] OP_DEP    = 2'd3;

	typedef struct packed {
		logic capture;
		logic exec_simple;
		logic scan_start;
		logic scan_rd;
		logic round_next;
		logic finish;
		logic dep_rd;
		logic dep_apply;
		logic out_load;
	} tds_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            scan_last;
		logic            pipe_busy;
		logic            kahn_more;
		logic            out_free;
	} tds_status_t;

endpackage

// ===== sv/task_dependency_scoreboard.sv =====
// ----------------------------------------------------------------------------
// Task dependency scoreboard
// Step table with dependency checks, claiming, deadlines and flow status.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Clear, load, status, cancel and the
// single-step commands other than done pass from decode straight to the
// response state; done first reads the step's dependency mask in its own
// state. Claim next and sweep walk every loaded step through the dependency
// and deadline memories. Commit runs Kahn elimination, one pass over the N
// steps per round, at most N rounds. The two step memories are read through
// a single shared address. A new transaction is taken once the previous
// result has been placed in the output register.
module task_dependency_scoreboard
	import tds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     command,
	input  logic [3:0]           step_index,
	input  logic [MAX_STEPS-1:0] step_deps,
	input  logic [TIME_W-1:0]    deadline,
	input  logic [TIME_W-1:0]    now,
	input  logic [7:0]           worker,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RC_W-1:0]      result_code,
	output logic                 claim_found,
	output logic [3:0]           claimed_index,
	output logic [MAX_STEPS-1:0] overdue_mask,
	output logic [FLOW_W-1:0]    flow_state,
	output logic [CNT_W-1:0]     step_count
);

	`include "task_dependency_scoreboard_macros.svh"

	tds_cmd_t    cmd;
	tds_status_t st;

	tds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	tds_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.command       (command),
		.step_index    (step_index),
		.step_deps     (step_deps),
		.deadline      (deadline),
		.now           (now),
		.worker        (worker),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_code   (result_code),
		.claim_found   (claim_found),
		.claimed_index (claimed_index),
		.overdue_mask  (overdue_mask),
		.flow_state    (flow_state),
		.step_count    (step_count)
	);

	`TDS_ASSERT_NOW(a_count_range, out_valid, step_count <= CNT_W'(MAX_STEPS))
	`TDS_ASSERT_NOW(a_claim_ok, out_valid && claim_found, result_code == RC_OK)
	`TDS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

// ===== sv/tds_ctrl.sv =====
// ----------------------------------------------------------------------------
// Task dependency scoreboard controller
// Sequences decode, table scans, elimination rounds and the response.
// ----------------------------------------------------------------------------
module tds_ctrl
	import tds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  tds_status_t st,
	output tds_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_DEPW   = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.op)
					OP_SCAN, OP_KAHN: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					OP_DEP: begin
						cmd.dep_rd = 1'b1;
						state_d    = S_DEPW;
					end
					default: begin
						cmd.exec_simple = 1'b1;
						state_d         = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (st.scan_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				// wait for the last read to land before deciding
				if (!st.pipe_busy) begin
					if (st.kahn_more) begin
						cmd.round_next = 1'b1;
						state_d        = S_SCAN;
					end else begin
						cmd.finish = 1'b1;
						state_d    = S_RESP;
					end
				end
			end
			S_DEPW: begin
				cmd.dep_apply = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== sv/tds_dpath.sv =====
// ----------------------------------------------------------------------------
// Task dependency scoreboard datapath
// Step table, dependency and deadline memories, scan logic and result register.
// ----------------------------------------------------------------------------
module tds_dpath
	import tds_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  tds_cmd_t               cmd,
	output tds_status_t            st,
	input  logic [CMD_W-1:0]       command,
	input  logic [3:0]             step_index,
	input  logic [MAX_STEPS-1:0]   step_deps,
	input  logic [TIME_W-1:0]      deadline,
	input  logic [TIME_W-1:0]      now,
	input  logic [7:0]             worker,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [RC_W-1:0]        result_code,
	output logic                   claim_found,
	output logic [3:0]             claimed_index,
	output logic [MAX_STEPS-1:0]   overdue_mask,
	output logic [FLOW_W-1:0]      flow_state,
	output logic [CNT_W-1:0]       step_count
);

	// captured transaction
	logic [CMD_W-1:0]     cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [MAX_STEPS-1:0] deps_q;
	logic [TIME_W-1:0]    dl_q;
	logic [TIME_W-1:0]    now_q;
	logic [7:0]           worker_q;

	logic [CNT_W-1:0]     count_q;
	logic                 committed_q;

	// one flag vector per step state
	logic [MAX_STEPS-1:0] pend_q, claim_q, done_q, fail_q, over_q, canc_q;
	logic [MAX_STEPS-1:0] pend_d, claim_d, done_d, fail_d, over_d, canc_d;

	logic [MAX_STEPS-1:0] dep_mem [MAX_STEPS];
	logic [TIME_W-1:0]    dl_mem  [MAX_STEPS];
	logic [MAX_STEPS-1:0] rd_dep_s1;
	logic [TIME_W-1:0]    rd_dl_s1;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic [IDX_W-1:0]     addr_q;
	logic [MAX_STEPS-1:0] remaining_q, removable_q;
	logic                 first_q, unknown_q;
	logic                 found_q;
	logic [IDX_W-1:0]     cidx_q;
	logic [MAX_STEPS-1:0] omask_q;
	logic [RC_W-1:0]      rc_q;

	logic [MAX_STEPS-1:0] loaded;
	logic [MAX_STEPS-1:0] done_ld;
	logic [MAX_STEPS-1:0] rem_next;
	logic [MAX_STEPS-1:0] live;
	logic                 in_range, load_ok, worker_ok, is_sweep;
	logic                 deps_ok, expired, claim_hit;
	logic [RC_W-1:0]      rc_simple;
	logic [OP_W-1:0]      op_sel;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic [ST_W-1:0]      wr_code;
	logic                 cancel_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 every_done, any_canc, any_live, any_fail;
	logic [FLOW_W-1:0]    flow_d;

	always_comb begin
		for (int k = 0; k < MAX_STEPS; k++)
			loaded[k] = (CNT_W'(k) < count_q);
	end

	assign done_ld   = done_q & loaded;
	assign rem_next  = remaining_q & ~removable_q;
	assign live      = (pend_q | claim_q | over_q) & loaded;
	assign in_range  = (CNT_W'(idx_q) < count_q);
	assign load_ok   = !committed_q && (count_q != CNT_W'(MAX_STEPS));
	assign worker_ok = (worker_q[WORKER_BITS-1:0] != '0);
	assign is_sweep  = (cmd_q == CMD_SWEEP) || (cmd_q == CMD_CLAIM);
	assign deps_ok   = ((rd_dep_s1 & done_ld) == rd_dep_s1);
	assign expired   = valid_s1 && is_sweep && (rd_dl_s1 != '0) && (rd_dl_s1 < now_q)
		&& (pend_q[idx_s1] || claim_q[idx_s1]);
	assign claim_hit = valid_s1 && (cmd_q == CMD_CLAIM) && pend_q[idx_s1] && !expired
		&& deps_ok && !found_q;

	// result of commands finished in the decode cycle
	always_comb begin
		rc_simple = RC_OK;
		case (cmd_q)
			CMD_CLEAR: rc_simple = RC_OK;
			CMD_LOAD: begin
				if (committed_q)
					rc_simple = RC_COMMITTED;
				else if (!load_ok)
					rc_simple = RC_FULL;
			end
			CMD_COMMIT: begin
				if (committed_q)
					rc_simple = RC_COMMITTED;
				else
					rc_simple = RC_EMPTY;
			end
			CMD_DONE, CMD_FAILED, CMD_UNCLAIM: begin
				if (!committed_q)
					rc_simple = RC_NOT_COMMITTED;
				else if (!in_range)
					rc_simple = RC_NO_STEP;
				else if (cmd_q == CMD_UNCLAIM)
					rc_simple = claim_q[idx_q] ? RC_OK : RC_NOT_CLAIMED;
				else if (done_q[idx_q])
					rc_simple = RC_ALREADY_DONE;
				else if (canc_q[idx_q])
					rc_simple = RC_CANCELLED;
			end
			CMD_CLAIM: begin
				if (!committed_q)
					rc_simple = RC_NOT_COMMITTED;
				else if (!worker_ok)
					rc_simple = RC_BAD_WORKER;
			end
			CMD_CANCEL, CMD_SWEEP, CMD_STATUS: begin
				if (!committed_q)
					rc_simple = RC_NOT_COMMITTED;
			end
			default: rc_simple = RC_OK;
		endcase
	end

	// pick how the transaction is carried out
	always_comb begin
		op_sel = OP_SIMPLE;
		if (cmd_q == CMD_COMMIT && !committed_q && count_q != '0)
			op_sel = OP_KAHN;
		else if (cmd_q == CMD_DONE && committed_q && in_range && !done_q[idx_q]
			&& !canc_q[idx_q])
			op_sel = OP_DEP;
		else if (committed_q && count_q != '0
			&& (cmd_q == CMD_SWEEP || (cmd_q == CMD_CLAIM && worker_ok)))
			op_sel = OP_SCAN;
	end

	assign st.op        = op_sel;
	assign st.scan_last = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);
	assign st.pipe_busy = valid_s1;
	assign st.kahn_more = (cmd_q == CMD_COMMIT) && (removable_q != '0) && (rem_next != '0);
	assign st.out_free  = !out_valid || out_ready;

	// single-entry state writes, and the cancel of every live step
	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = idx_q;
		wr_code   = ST_PENDING;
		cancel_en = 1'b0;
		if (cmd.exec_simple) begin
			if (cmd_q == CMD_LOAD && load_ok) begin
				wr_en  = 1'b1;
				wr_idx = count_q[IDX_W-1:0];
			end else if (cmd_q == CMD_UNCLAIM && rc_simple == RC_OK) begin
				wr_en = 1'b1;
			end else if (cmd_q == CMD_FAILED && rc_simple == RC_OK) begin
				wr_en   = 1'b1;
				wr_code = ST_FAILED;
			end else if (cmd_q == CMD_CANCEL && committed_q) begin
				cancel_en = 1'b1;
			end
		end else if (cmd.dep_apply && deps_ok) begin
			wr_en   = 1'b1;
			wr_code = ST_DONE;
		end else if (expired) begin
			wr_en   = 1'b1;
			wr_idx  = idx_s1;
			wr_code = ST_OVERDUE;
		end else if (claim_hit) begin
			wr_en   = 1'b1;
			wr_idx  = idx_s1;
			wr_code = ST_CLAIMED;
		end
	end

	always_comb begin
		pend_d  = pend_q;
		claim_d = claim_q;
		done_d  = done_q;
		fail_d  = fail_q;
		over_d  = over_q;
		canc_d  = canc_q;
		for (int k = 0; k < MAX_STEPS; k++) begin
			if (wr_en && wr_idx == IDX_W'(k)) begin
				pend_d[k]  = (wr_code == ST_PENDING);
				claim_d[k] = (wr_code == ST_CLAIMED);
				done_d[k]  = (wr_code == ST_DONE);
				fail_d[k]  = (wr_code == ST_FAILED);
				over_d[k]  = (wr_code == ST_OVERDUE);
				canc_d[k]  = (wr_code == ST_CANCELLED);
			end
		end
		if (cancel_en) begin
			pend_d  = pend_q & ~live;
			claim_d = claim_q & ~live;
			over_d  = over_q & ~live;
			canc_d  = canc_q | live;
		end
	end

	always_ff @(posedge clk) begin
		pend_q  <= pend_d;
		claim_q <= claim_d;
		done_q  <= done_d;
		fail_q  <= fail_d;
		over_q  <= over_d;
		canc_q  <= canc_d;
	end

	// dependency and deadline memories, one read port each
	assign rd_addr = cmd.dep_rd ? idx_q : addr_q;

	always_ff @(posedge clk) begin
		if (cmd.exec_simple && cmd_q == CMD_LOAD && load_ok) begin
			dep_mem[count_q[IDX_W-1:0]] <= deps_q;
			dl_mem[count_q[IDX_W-1:0]]  <= dl_q;
		end
		if (cmd.scan_rd || cmd.dep_rd) begin
			rd_dep_s1 <= dep_mem[rd_addr];
			rd_dl_s1  <= dl_mem[rd_addr];
		end
		idx_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= cmd.scan_rd;
	end

	// capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= command;
			idx_q    <= step_index;
			deps_q   <= step_deps;
			dl_q     <= deadline;
			now_q    <= now;
			worker_q <= worker;
			found_q  <= 1'b0;
			cidx_q   <= '0;
			omask_q  <= '0;
		end
		if (cmd.scan_start) begin
			addr_q      <= '0;
			remaining_q <= loaded;
			removable_q <= '0;
			first_q     <= 1'b1;
			unknown_q   <= 1'b0;
		end else if (cmd.round_next) begin
			addr_q      <= '0;
			remaining_q <= rem_next;
			removable_q <= '0;
			first_q     <= 1'b0;
		end else if (cmd.scan_rd) begin
			addr_q <= addr_q + IDX_W'(1);
		end
		if (valid_s1 && cmd_q == CMD_COMMIT) begin
			if (first_q && (rd_dep_s1 & ~loaded) != '0)
				unknown_q <= 1'b1;
			if (remaining_q[idx_s1] && (rd_dep_s1 & remaining_q) == '0)
				removable_q[idx_s1] <= 1'b1;
		end
		if (expired)
			omask_q[idx_s1] <= 1'b1;
		if (claim_hit) begin
			found_q <= 1'b1;
			cidx_q  <= idx_s1;
		end
		if (cmd.exec_simple)
			rc_q <= rc_simple;
		else if (cmd.dep_apply)
			rc_q <= deps_ok ? RC_OK : RC_DEPS_PENDING;
		else if (cmd.finish) begin
			if (cmd_q != CMD_COMMIT)
				rc_q <= RC_OK;
			else if (unknown_q)
				rc_q <= RC_UNKNOWN_DEP;
			else if (rem_next != '0)
				rc_q <= RC_CYCLIC;
			else
				rc_q <= RC_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			committed_q <= 1'b0;
		end else if (cmd.exec_simple) begin
			if (cmd_q == CMD_CLEAR) begin
				count_q     <= '0;
				committed_q <= 1'b0;
			end else if (cmd_q == CMD_LOAD && load_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (cmd.finish && cmd_q == CMD_COMMIT) begin
			if (!unknown_q && rem_next == '0)
				committed_q <= 1'b1;
			else
				count_q <= '0;
		end
	end

	// aggregate flow state over the loaded steps
	assign every_done = (done_ld == loaded);
	assign any_canc   = |(canc_q & loaded);
	assign any_live   = |live;
	assign any_fail   = |(fail_q & loaded);

	always_comb begin
		flow_d = FLOW_ACTIVE;
		if (!committed_q)
			flow_d = FLOW_ACTIVE;
		else if (every_done)
			flow_d = FLOW_DONE;
		else if (any_canc)
			flow_d = FLOW_CANCELLED;
		else if (!any_live && any_fail)
			flow_d = FLOW_FAILED;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.out_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_code   <= rc_q;
			claim_found   <= found_q;
			claimed_index <= cidx_q;
			overdue_mask  <= omask_q;
			flow_state    <= flow_d;
			step_count    <= count_q;
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Task dependency scoreboard testbench
// Drives command transactions with random idling on both channels, predicts
// every result from an internal copy of the step table and checks each field.
// ----------------------------------------------------------------------------
module tb;
	import tds_pkg::*;

	typedef struct {
		logic [CMD_W-1:0]     cmd;
		logic [3:0]           idx;
		logic [MAX_STEPS-1:0] deps;
		logic [TIME_W-1:0]    dl;
		logic [TIME_W-1:0]    tnow;
		logic [7:0]           wk;
	} cmd_item_t;

	typedef struct {
		logic [RC_W-1:0]      rc;
		logic                 found;
		logic [3:0]           cidx;
		logic [MAX_STEPS-1:0] omask;
		logic [FLOW_W-1:0]    flow;
		logic [CNT_W-1:0]     cnt;
	} reply_t;

	class step_table_sb;
		logic [ST_W-1:0]      st [MAX_STEPS];
		logic [7:0]           owner [MAX_STEPS];
		logic [MAX_STEPS-1:0] dmask [MAX_STEPS];
		logic [TIME_W-1:0]    dline [MAX_STEPS];
		int                   count;
		bit                   committed;
		reply_t               pending_replies [$];
		int                   errors;
		int                   checked;

		function logic [MAX_STEPS-1:0] done_set();
			logic [MAX_STEPS-1:0] m;
			m = '0;
			for (int i = 0; i < count; i++)
				if (st[i] == ST_DONE) m[i] = 1'b1;
			return m;
		endfunction

		function bit ready_to_run(int i);
			return (dmask[i] & done_set()) == dmask[i];
		endfunction

		function bit cyclic();
			logic [MAX_STEPS-1:0] left, removable;
			left = '0;
			for (int i = 0; i < count; i++) left[i] = 1'b1;
			do begin
				removable = '0;
				for (int i = 0; i < count; i++)
					if (left[i] && (dmask[i] & left) == '0) removable[i] = 1'b1;
				left &= ~removable;
			end while (left != '0 && removable != '0);
			return left != '0;
		endfunction

		function logic [MAX_STEPS-1:0] expire(logic [TIME_W-1:0] t);
			logic [MAX_STEPS-1:0] m;
			m = '0;
			for (int i = 0; i < count; i++)
				if (dline[i] != 0 && dline[i] < t &&
						(st[i] == ST_PENDING || st[i] == ST_CLAIMED)) begin
					st[i] = ST_OVERDUE;
					m[i] = 1'b1;
				end
			return m;
		endfunction

		function logic [FLOW_W-1:0] flow();
			bit every_done, any_canc, any_act, any_fail;
			every_done = 1; any_canc = 0; any_act = 0; any_fail = 0;
			for (int i = 0; i < count; i++) begin
				if (st[i] != ST_DONE) every_done = 0;
				if (st[i] == ST_CANCELLED) any_canc = 1;
				if (st[i] == ST_PENDING || st[i] == ST_CLAIMED || st[i] == ST_OVERDUE)
					any_act = 1;
				if (st[i] == ST_FAILED) any_fail = 1;
			end
			if (every_done) return FLOW_DONE;
			if (any_canc) return FLOW_CANCELLED;
			if (!any_act && any_fail) return FLOW_FAILED;
			return FLOW_ACTIVE;
		endfunction

		function void note_command(cmd_item_t c);
			reply_t r;
			logic [MAX_STEPS-1:0] known;
			r = '{RC_OK, 1'b0, 4'd0, '0, FLOW_ACTIVE, '0};
			if (c.cmd == CMD_CLEAR) begin
				count = 0;
				committed = 0;
			end else if (c.cmd == CMD_LOAD) begin
				if (committed) r.rc = RC_COMMITTED;
				else if (count >= MAX_STEPS) r.rc = RC_FULL;
				else begin
					dmask[count] = c.deps;
					dline[count] = c.dl;
					st[count] = ST_PENDING;
					owner[count] = 8'd0;
					count++;
				end
			end else if (c.cmd == CMD_COMMIT) begin
				if (committed) r.rc = RC_COMMITTED;
				else if (count == 0) r.rc = RC_EMPTY;
				else begin
					known = '0;
					for (int i = 0; i < count; i++) known[i] = 1'b1;
					for (int i = 0; i < count; i++)
						if ((dmask[i] & ~known) != '0) r.rc = RC_UNKNOWN_DEP;
					if (r.rc == RC_OK && cyclic()) r.rc = RC_CYCLIC;
					if (r.rc == RC_OK) committed = 1;
					else count = 0;
				end
			end else if (c.cmd <= CMD_STATUS && !committed) begin
				r.rc = RC_NOT_COMMITTED;
			end else if (c.cmd == CMD_DONE || c.cmd == CMD_FAILED || c.cmd == CMD_UNCLAIM) begin
				if (c.idx >= count) r.rc = RC_NO_STEP;
				else if (c.cmd == CMD_UNCLAIM) begin
					if (st[c.idx] != ST_CLAIMED) r.rc = RC_NOT_CLAIMED;
					else begin
						st[c.idx] = ST_PENDING;
						owner[c.idx] = 8'd0;
					end
				end else if (st[c.idx] == ST_DONE) r.rc = RC_ALREADY_DONE;
				else if (st[c.idx] == ST_CANCELLED) r.rc = RC_CANCELLED;
				else if (c.cmd == CMD_DONE && !ready_to_run(c.idx)) r.rc = RC_DEPS_PENDING;
				else st[c.idx] = (c.cmd == CMD_DONE) ? ST_DONE : ST_FAILED;
			end else if (c.cmd == CMD_CLAIM) begin
				if (c.wk == 0) r.rc = RC_BAD_WORKER;
				else begin
					r.omask = expire(c.tnow);
					for (int i = 0; i < count; i++)
						if (st[i] == ST_PENDING && ready_to_run(i)) begin
							st[i] = ST_CLAIMED;
							owner[i] = c.wk;
							r.found = 1'b1;
							r.cidx = 4'(i);
							break;
						end
				end
			end else if (c.cmd == CMD_CANCEL) begin
				for (int i = 0; i < count; i++)
					if (st[i] == ST_PENDING || st[i] == ST_CLAIMED || st[i] == ST_OVERDUE) begin
						st[i] = ST_CANCELLED;
						owner[i] = 8'd0;
					end
			end else if (c.cmd == CMD_SWEEP) begin
				r.omask = expire(c.tnow);
			end
			r.flow = committed ? flow() : FLOW_ACTIVE;
			r.cnt = CNT_W'(count);
			pending_replies.push_back(r);
		endfunction

		function void check_reply(reply_t a);
			reply_t e;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result, rc %0d", $time, a.rc);
				errors++;
				return;
			end
			e = pending_replies.pop_front();
			checked++;
			if (a.rc !== e.rc) begin
				$display("%0t: result_code exp %0d got %0d", $time, e.rc, a.rc); errors++;
			end
			if (a.found !== e.found) begin
				$display("%0t: claim_found exp %0d got %0d", $time, e.found, a.found); errors++;
			end
			if (a.cidx !== e.cidx) begin
				$display("%0t: claimed_index exp %0d got %0d", $time, e.cidx, a.cidx); errors++;
			end
			if (a.omask !== e.omask) begin
				$display("%0t: overdue_mask exp %h got %h", $time, e.omask, a.omask); errors++;
			end
			if (a.flow !== e.flow) begin
				$display("%0t: flow_state exp %0d got %0d", $time, e.flow, a.flow); errors++;
			end
			if (a.cnt !== e.cnt) begin
				$display("%0t: step_count exp %0d got %0d", $time, e.cnt, a.cnt); errors++;
			end
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = '0;
	logic [3:0]           step_index = '0;
	logic [MAX_STEPS-1:0] step_deps = '0;
	logic [TIME_W-1:0]    deadline = '0;
	logic [TIME_W-1:0]    now = '0;
	logic [7:0]           worker = '0;
	logic                 out_valid;
	logic                 out_ready = 0;
	logic [RC_W-1:0]      result_code;
	logic                 claim_found;
	logic [3:0]           claimed_index;
	logic [MAX_STEPS-1:0] overdue_mask;
	logic [FLOW_W-1:0]    flow_state;
	logic [CNT_W-1:0]     step_count;

	step_table_sb sb = new();
	int  send_idle_pct = 33;
	int  recv_idle_pct = 79;
	bit  recv_hold = 0;
	int  sent = 0;
	longint cycles = 0;
	logic [TIME_W-1:0] clock_now = 40'd1000;

	task_dependency_scoreboard uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reply('{result_code, claim_found, claimed_index, overdue_mask,
				flow_state, step_count});
		out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send(cmd_item_t c);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid   <= 1'b1;
		command    <= c.cmd;
		step_index <= c.idx;
		step_deps  <= c.deps;
		deadline   <= c.dl;
		now        <= c.tnow;
		worker     <= c.wk;
		do @(posedge clk); while (!in_ready);
		sb.note_command(c);
		sent++;
		// drop valid over the decode cycle, when the block is never ready
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cmd(logic [CMD_W-1:0] op, logic [3:0] i = 0,
			logic [MAX_STEPS-1:0] d = 0, logic [TIME_W-1:0] dl = 0,
			logic [TIME_W-1:0] t = 0, logic [7:0] w = 1);
		send('{op, i, d, dl, t, w});
	endtask

	task automatic drain();
		while (sb.pending_replies.size() != 0) @(posedge clk);
	endtask

	// a well-formed acyclic table: each step depends only on earlier ones
	task automatic build_flow(int n);
		logic [MAX_STEPS-1:0] d;
		for (int i = 0; i < n; i++) begin
			d = (i == 0) ? '0 : MAX_STEPS'(($urandom() & ((32'h1 << i) - 1)) & $urandom());
			cmd(CMD_LOAD, 0, d,
				($urandom_range(2) == 0) ? 40'd0 : clock_now + TIME_W'($urandom_range(200)));
		end
		cmd(CMD_COMMIT);
	endtask

	// keep sending until n more transactions have gone in
	task automatic random_phase(int n);
		cmd_item_t c;
		int k;
		int stop;
		stop = sent + n;
		while (sent < stop) begin
			if (!sb.committed && sb.count == 0) begin
				build_flow($urandom_range(1, 6) + (($urandom_range(9) == 0) ? 10 : 0));
				continue;
			end
			k = $urandom_range(99);
			clock_now += TIME_W'($urandom_range(20));
			c = '{CMD_STATUS, 4'($urandom_range(sb.count + 1)), MAX_STEPS'($urandom()),
				TIME_W'({$urandom(), $urandom()}), clock_now,
				($urandom_range(7) == 0) ? 8'd0 : 8'($urandom())};
			if (k < 30) c.cmd = CMD_CLAIM;
			else if (k < 55) c.cmd = CMD_DONE;
			else if (k < 62) c.cmd = CMD_FAILED;
			else if (k < 69) c.cmd = CMD_UNCLAIM;
			else if (k < 77) c.cmd = CMD_SWEEP;
			else if (k < 80) c.cmd = CMD_CANCEL;
			else if (k < 85) c.cmd = CMD_STATUS;
			else if (k < 90) c.cmd = CMD_CLEAR;
			else if (k < 94) c.cmd = 4'($urandom_range(10, 15));
			else if (k < 97) c.cmd = CMD_LOAD;
			else c.cmd = CMD_COMMIT;
			if (c.cmd == CMD_CLAIM && $urandom_range(3) == 0)
				c.tnow = TIME_W'({$urandom(), $urandom()});
			send(c);
			if (sb.committed && sb.flow() != FLOW_ACTIVE && $urandom_range(2) == 0)
				cmd(CMD_CLEAR);
		end
	endtask

	initial begin
		sb.count = 0; sb.committed = 0; sb.errors = 0; sb.checked = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: uncommitted commands, empty commit, errors and limits
		cmd(CMD_STATUS);
		cmd(CMD_CLAIM, 0, 0, 0, 5, 8'hFF);
		cmd(CMD_COMMIT);
		cmd(CMD_LOAD, 0, 16'h0002);
		cmd(CMD_LOAD, 0, 16'h0000);
		cmd(CMD_COMMIT);
		cmd(CMD_LOAD, 0, 16'h0001);
		cmd(CMD_COMMIT);
		cmd(CMD_LOAD, 0, 16'h0004);
		cmd(CMD_COMMIT);
		for (int i = 0; i < 17; i++)
			cmd(CMD_LOAD, 0, (i == 0) ? 16'h0 : 16'h1 << (i - 1),
				(i == 3) ? 40'hFF_FFFF_FFFF : (i == 2 ? 40'd100 : 40'd0));
		cmd(CMD_COMMIT);
		cmd(CMD_COMMIT);
		cmd(CMD_LOAD);
		cmd(CMD_CLAIM, 0, 0, 0, 100, 8'd0);
		cmd(CMD_CLAIM, 0, 0, 0, 100, 8'd1);
		cmd(CMD_DONE, 1);
		cmd(CMD_UNCLAIM, 0);
		cmd(CMD_UNCLAIM, 0);
		cmd(CMD_CLAIM, 0, 0, 0, 40'hFF_FFFF_FFFF, 8'h80);
		cmd(CMD_DONE, 0);
		cmd(CMD_DONE, 0);
		cmd(CMD_FAILED, 15);
		cmd(CMD_DONE, 15);
		cmd(CMD_SWEEP, 0, 0, 0, 40'hFF_FFFF_FFFF);
		cmd(CMD_CANCEL);
		cmd(CMD_DONE, 1);
		cmd(4'd15);
		cmd(CMD_CLEAR);
		drain();

		random_phase(160);
		drain();
		send_idle_pct = 79; recv_idle_pct = 33;
		random_phase(160);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;

		// long hold-off on the receiver while commands keep coming
		fork
			begin
				recv_hold = 1;
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
			random_phase(20);
		join
		drain();
		random_phase(150);
		drain();
		repeat (400) @(posedge clk);

		$display("Sent %0d command transactions, %0d results checked, covering load,",
			sent, sb.checked);
		$display("commit errors, claim, deadlines, step moves, cancel and status.");
		if (sb.errors == 0 && sb.pending_replies.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/tds_pkg.sv
sv/tds_ctrl.sv
sv/tds_dpath.sv
sv/task_dependency_scoreboard.sv
tb/tb.sv
